/* sv/pinhole_camera_ray_generator_macros.svh */
// Assertion macros shared by the pinhole ray generator RTL.
// Included by the modules that carry concurrent checks.
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_MACROS_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_MACROS_SVH

// Same-cycle implication, checking is off while reset is high
`define PRCG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checking is off while reset is high
`define PRCG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/prcg_pkg.sv */
// Shared widths, register indexes, types and the reciprocal square root seed table
// for the pinhole ray generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prcg_pkg;

  localparam int ScrW  = 16;  // screen coordinate, Q1.15
  localparam int TanW  = 16;  // half field of view tangent, Q4.12
  localparam int AxW   = 48;  // packed basis axis
  localparam int OrgW  = 32;  // origin, Q16.16
  localparam int DirW  = 16;  // direction, Q1.14
  localparam int CamW  = 33;  // scaled screen value, Q.27
  localparam int PrdW  = 49;  // axis component times camera value
  localparam int FwdW  = 43;  // forward component times 1.0 in Q.27
  localparam int WldW  = 51;  // world direction, signed
  localparam int MagW  = 50;  // world direction magnitude
  localparam int PosW  = 6;   // leading one position in a magnitude
  localparam int NrmW  = 30;  // normalised magnitude, top bit at 29
  localparam int MagAW = 31;  // normalised magnitude after optional doubling
  localparam int SqW   = 60;  // square of a normalised magnitude
  localparam int SumW  = 62;  // sum of squares
  localparam int ShW   = 32;  // sum of squares shifted down by 30
  localparam int YW    = 33;  // reciprocal square root estimate
  localparam int TW    = 34;  // y squared, shifted down by 30
  localparam int DifW  = 32;  // 3.0 minus correction term
  localparam int RndW  = 18;  // rounded direction before saturation

  localparam logic [2:0] REG_TAN_X = 3'd0;
  localparam logic [2:0] REG_TAN_Y = 3'd1;
  localparam logic [2:0] REG_RIGHT = 3'd2;
  localparam logic [2:0] REG_UP    = 3'd3;
  localparam logic [2:0] REG_FWD   = 3'd4;
  localparam logic [2:0] REG_ORG_X = 3'd5;
  localparam logic [2:0] REG_ORG_Y = 3'd6;
  localparam logic [2:0] REG_ORG_Z = 3'd7;

  localparam logic [DifW-1:0] THREE_Q30 = 32'hC000_0000;
  localparam logic [63:0]     HALF_Q46  = 64'h0000_2000_0000_0000;
  localparam logic [RndW-1:0] UNIT_Q14  = 18'd16384;

  // Normalised magnitudes with their signs, carried alongside the square root unit
  typedef struct packed {
    logic [2:0][MagAW-1:0] mag;
    logic [2:0]            neg;
  } side_t;

  // Operand pair travelling through the Newton steps
  typedef struct packed {
    logic [ShW-1:0] sh;
    logic [YW-1:0]  y;
  } rsq_t;

  function automatic logic [YW-1:0] rsq_seed(input logic [1:0] idx);
    logic [YW-1:0] v;
    unique case (idx)
      2'd0:    v = 33'd876706527;
      2'd1:    v = 33'd876706527;
      2'd2:    v = 33'd679093955;
      default: v = 33'd573939140;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/prcg_front.sv */
// Front of the ray pipeline: screen scaling, rotation into world space, magnitude,
// normalising shift and sum of squares with the square root seed. Uses prcg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prcg_front (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [prcg_pkg::ScrW-1:0] screen_x,
  input  wire logic [prcg_pkg::ScrW-1:0] screen_y,
  input  wire logic [prcg_pkg::TanW-1:0] tan_x,
  input  wire logic [prcg_pkg::TanW-1:0] tan_y,
  input  wire logic [prcg_pkg::AxW-1:0]  right_axis,
  input  wire logic [prcg_pkg::AxW-1:0]  up_axis,
  input  wire logic [prcg_pkg::AxW-1:0]  forward_axis,
  output prcg_pkg::side_t                side,
  output prcg_pkg::rsq_t                 rsq
);
  import prcg_pkg::*;

  // stage 1: scaled camera x and y
  logic signed [CamW-1:0] cam_x, cam_y;
  // stage 2: per-axis products
  logic signed [2:0][PrdW-1:0] prd_r, prd_u;
  logic signed [2:0][FwdW-1:0] prd_f;
  // stage 3: magnitudes and signs
  logic [2:0][MagW-1:0] mag3;
  logic [2:0]           neg3, neg4, neg5, neg6;
  // stage 4: leading one position
  logic [2:0][MagW-1:0] mag4;
  logic [PosW-1:0]      pos4;
  // stage 5: normalised magnitudes
  logic [2:0][NrmW-1:0] mag5;
  // stage 6: squares
  logic [2:0][NrmW-1:0] mag6;
  logic [2:0][SqW-1:0]  sq6;

  logic [MagW-1:0]      any_mag;
  logic [PosW-1:0]      pos_next;
  logic [SumW-1:0]      sum_sq;
  logic                 low_sum;
  logic [SumW-1:0]      sum_adj;

  always_ff @(posedge clk) begin
    if (en) begin
      cam_x <= $signed(screen_x) * $signed({1'b0, tan_x});
      cam_y <= $signed(screen_y) * $signed({1'b0, tan_y});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prd_r[k] <= PrdW'($signed(right_axis[16*k +: 16])) * PrdW'(cam_x);
        prd_u[k] <= PrdW'($signed(up_axis[16*k +: 16])) * PrdW'(cam_y);
        prd_f[k] <= $signed({forward_axis[16*k +: 16], 27'd0});
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [WldW-1:0] w;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        w = WldW'($signed(prd_r[k])) + WldW'($signed(prd_u[k]))
          + WldW'($signed(prd_f[k]));
        neg3[k] <= w[WldW-1];
        mag3[k] <= w[WldW-1] ? MagW'(-w) : MagW'(w);
      end
    end
  end

  // leading one of the OR of the three is that of the largest
  always_comb begin
    any_mag  = mag3[0] | mag3[1] | mag3[2];
    pos_next = '0;
    for (int i = 0; i < MagW; i++) begin
      if (any_mag[i]) pos_next = PosW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag4 <= mag3;
      neg4 <= neg3;
      pos4 <= pos_next;
    end
  end

  // bring the largest into [2^29, 2^30); right shifts truncate
  always_ff @(posedge clk) begin
    logic [MagW-1:0] shifted;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (pos4 >= PosW'(NrmW - 1)) shifted = mag4[k] >> (pos4 - PosW'(NrmW - 1));
        else shifted = mag4[k] << (PosW'(NrmW - 1) - pos4);
        mag5[k] <= shifted[NrmW-1:0];
      end
      neg5 <= neg4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq6[k] <= SqW'(mag5[k]) * SqW'(mag5[k]);
      end
      mag6 <= mag5;
      neg6 <= neg5;
    end
  end

  // double the magnitudes and quadruple the sum once when the sum falls below 2^60
  always_comb begin
    sum_sq  = SumW'(sq6[0]) + SumW'(sq6[1]) + SumW'(sq6[2]);
    low_sum = (sum_sq[SumW-1:60] == 2'd0);
    sum_adj = low_sum ? (sum_sq << 2) : sum_sq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        side.mag[k] <= low_sum ? {mag6[k], 1'b0} : {1'b0, mag6[k]};
      end
      side.neg <= neg6;
      rsq.sh   <= sum_adj[SumW-1:30];
      rsq.y    <= rsq_seed(sum_adj[SumW-1:60]);
    end
  end

endmodule
`default_nettype wire

/* sv/prcg_rsq_step.sv */
// One Newton step of the reciprocal square root, y = y * (3 - f*y*y) / 2,
// spread over three registered multiplies. Uses prcg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prcg_rsq_step (
  input  wire logic           clk,
  input  wire logic           en,
  input  prcg_pkg::rsq_t      din,
  output prcg_pkg::rsq_t      dout
);
  import prcg_pkg::*;

  logic [TW-1:0]  t_a, u_b;
  rsq_t           op_a, op_b;
  logic [63:0]    yy, st, yd;
  logic [DifW-1:0] diff;

  assign yy = 64'(din.y) * 64'(din.y);

  always_ff @(posedge clk) begin
    if (en) begin
      t_a  <= yy[63:30];
      op_a <= din;
    end
  end

  assign st = 64'(op_a.sh) * 64'(t_a);

  always_ff @(posedge clk) begin
    if (en) begin
      u_b  <= st[63:30];
      op_b <= op_a;
    end
  end

  // clamp the correction at zero when f*y*y exceeds three
  assign diff = (u_b < TW'(THREE_Q30)) ? DifW'(TW'(THREE_Q30) - u_b) : '0;
  assign yd   = 64'(op_b.y) * 64'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      dout.sh <= op_b.sh;
      dout.y  <= yd[63:31];
    end
  end

endmodule
`default_nettype wire

/* sv/pinhole_camera_ray_generator.sv */
// Pinhole camera primary ray generator: one screen position in, one ray out.
// Depends on prcg_pkg, prcg_front, prcg_rsq_step and the assertion macro header.
//
// The block turns a Q1.15 screen position into a world-space ray. x and y are
// scaled by the half field of view tangents, (sx, sy, 1) is rotated by the right,
// up and forward axes, and the result is normalised by four Newton steps of a
// reciprocal square root to a Q1.14 unit vector (a zero vector gives zeros). The
// camera position is sent unchanged as the ray origin. One item is taken every
// cycle while s_tready is high; each passes 21 pipeline registers and then the
// output register, the first loaded at the input transfer edge; twelve of the
// pipeline registers are the multiplier stages of the Newton steps.
// A skid register behind the output lets one finished ray wait while the pipeline
// still advances; s_tready drops only when that skid register is full. Write
// configuration only while no ray is in flight; writes to an index take effect at
// once.
`timescale 1ns / 1ps
`default_nettype none
`include "pinhole_camera_ray_generator_macros.svh"
module pinhole_camera_ray_generator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // screen_x [15:0], screen_y [31:16]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // ray_origin_x [31:0], ray_origin_y [63:32], ray_origin_z [95:64],
  // dir_x [111:96], dir_y [127:112], dir_z [143:128]
  output logic [143:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);
  import prcg_pkg::*;

  localparam int FrontStg = 7;
  localparam int RsqStg   = 12;
  localparam int NumStg   = FrontStg + RsqStg + 2;

  // configuration registers
  logic [TanW-1:0] tan_x, tan_y;
  logic [AxW-1:0]  right_axis, up_axis, forward_axis;
  logic [OrgW-1:0] origin_x, origin_y, origin_z;

  logic              en;
  logic [NumStg-1:0] vld;
  side_t             side_f;
  side_t             side_dly [RsqStg];
  rsq_t              rsq_c [5];
  logic [2:0][63:0]  prod;
  side_t             side_p;
  logic [2:0][DirW-1:0] dir_p;
  logic              last_in;
  logic [2:0][DirW-1:0] dir_o, dir_s;
  logic              skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      tan_x        <= TanW'(4096);
      tan_y        <= TanW'(4096);
      right_axis   <= AxW'(48'h0000_0000_4000);
      up_axis      <= AxW'(48'h0000_4000_0000);
      forward_axis <= AxW'(48'h4000_0000_0000);
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAN_X: tan_x        <= cfg_data[TanW-1:0];
        REG_TAN_Y: tan_y        <= cfg_data[TanW-1:0];
        REG_RIGHT: right_axis   <= cfg_data;
        REG_UP:    up_axis      <= cfg_data;
        REG_FWD:   forward_axis <= cfg_data;
        REG_ORG_X: origin_x     <= cfg_data[OrgW-1:0];
        REG_ORG_Y: origin_y     <= cfg_data[OrgW-1:0];
        REG_ORG_Z: origin_z     <= cfg_data[OrgW-1:0];
      endcase
    end
  end

  // the whole pipeline advances together; hold only while the skid register is full
  assign en       = ~skid_vld;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStg-2:0], s_tvalid};
    end
  end

  prcg_front u_front (
    .clk          (clk),
    .en           (en),
    .screen_x     (s_tdata[15:0]),
    .screen_y     (s_tdata[31:16]),
    .tan_x        (tan_x),
    .tan_y        (tan_y),
    .right_axis   (right_axis),
    .up_axis      (up_axis),
    .forward_axis (forward_axis),
    .side         (side_f),
    .rsq          (rsq_c[0])
  );

  for (genvar g = 0; g < 4; g++) begin : g_newton
    prcg_rsq_step u_step (
      .clk  (clk),
      .en   (en),
      .din  (rsq_c[g]),
      .dout (rsq_c[g+1])
    );
  end

  // carry magnitudes and signs alongside the Newton steps
  always_ff @(posedge clk) begin
    if (en) begin
      side_dly[0] <= side_f;
      for (int i = 1; i < RsqStg; i++) side_dly[i] <= side_dly[i-1];
    end
  end

  // scale each magnitude by the reciprocal length
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) prod[k] <= 64'(side_dly[RsqStg-1].mag[k]) * 64'(rsq_c[4].y);
      side_p <= side_dly[RsqStg-1];
    end
  end

  // round, saturate at 1.0 and apply the sign
  always_ff @(posedge clk) begin
    logic [63:0]     rnd;
    logic [RndW-1:0] d;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rnd = prod[k] + HALF_Q46;
        d   = rnd[63:46];
        if (d > UNIT_Q14) d = UNIT_Q14;
        dir_p[k] <= side_p.neg[k] ? DirW'(-d) : DirW'(d);
      end
    end
  end

  assign last_in = en & vld[NumStg-1];

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else if (m_tready | ~m_tvalid) begin
      if (skid_vld) begin
        m_tvalid <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        m_tvalid <= last_in;
      end
    end else if (last_in) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready | ~m_tvalid) begin
      dir_o <= skid_vld ? dir_s : dir_p;
    end else if (last_in) begin
      dir_s <= dir_p;
    end
  end

  // the user must keep the origin registers still while rays are in flight; the block does not enforce it
  assign m_tdata = {dir_o[2], dir_o[1], dir_o[0], origin_z, origin_y, origin_x};

  `PRCG_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_vld, m_tvalid, "skid full without output")
  `PRCG_ASSERT_NOW(a_ready_tracks_skid, clk, rst, 1'b1, s_tready == ~skid_vld, "ready mismatch")
  `PRCG_ASSERT_NXT(a_skid_drains, clk, rst, m_tvalid && m_tready && skid_vld, m_tvalid && !skid_vld, "skid not drained")
  `PRCG_ASSERT_NOW(a_dir_unit, clk, rst, m_tvalid, ($signed(m_tdata[111:96]) <= 16'sd16384) && ($signed(m_tdata[111:96]) >= -16'sd16384), "dir_x beyond unit")

endmodule
`default_nettype wire
